// File: rtl/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while out of reset.
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: rtl/eppr_pkg.sv
// Package for the epoch peak-to-peak rejector: types, codes and sizes.
package eppr_pkg;

  localparam int MAX_CHANNELS = 512;
  localparam int CH_IDX_W     = $clog2(MAX_CHANNELS);
  localparam int OUT_CH_W     = 9;
  localparam int SAMPLE_W     = 32;
  localparam int LIMIT_W      = 32;
  localparam int CFG_DATA_W   = 2 * LIMIT_W;
  localparam int NUM_CLASSES  = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CLASS_W      = 3;
  localparam int REASON_W     = 2;

  typedef enum logic [CLASS_W-1:0] {
    CLS_OTHER = 3'd0,
    CLS_MAG   = 3'd1,
    CLS_GRAD  = 3'd2,
    CLS_EEG   = 3'd3,
    CLS_EOG   = 3'd4,
    CLS_ECG   = 3'd5
  } chan_class_t;

  typedef enum logic [REASON_W-1:0] {
    REASON_NONE = 2'd0,
    REASON_HIGH = 2'd1,
    REASON_FLAT = 2'd2
  } reason_t;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAG  = 3'd0,
    REG_GRAD = 3'd1,
    REG_EEG  = 3'd2,
    REG_EOG  = 3'd3,
    REG_ECG  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               tested;
    logic [LIMIT_W-1:0] reject;
    logic [LIMIT_W-1:0] flat;
  } limit_sel_t;

endpackage

// File: rtl/eppr_if.sv
// Channel interfaces: sample stream, verdict stream and configuration writes.
interface eppr_sample_if;
  import eppr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [CLASS_W-1:0]         channel_class;
  logic                       channel_bad;
  logic                       last_of_channel;
  logic                       last_of_epoch;

  modport source (output valid, sample_value, channel_class, channel_bad,
                  output last_of_channel, last_of_epoch, input ready);
  modport sink   (input valid, sample_value, channel_class, channel_bad,
                  input last_of_channel, last_of_epoch, output ready);
endinterface

interface eppr_verdict_if;
  import eppr_pkg::*;
  logic                valid;
  logic                ready;
  logic                epoch_accepted;
  logic [REASON_W-1:0] reject_reason;
  logic [OUT_CH_W-1:0] offending_channel;
  logic [CLASS_W-1:0]  offending_class;

  modport source (output valid, epoch_accepted, reject_reason, offending_channel,
                  output offending_class, input ready);
  modport sink   (input valid, epoch_accepted, reject_reason, offending_channel,
                  input offending_class, output ready);
endinterface

interface eppr_cfg_if;
  import eppr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/eppr_limit_regs.sv
// Per-class limit registers and the lookup of one class's reject and flat limits.
module eppr_limit_regs import eppr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic [CLASS_W-1:0]    rd_class,
  output limit_sel_t            sel
);

  logic [CFG_DATA_W-1:0] limits [NUM_CLASSES];
  logic [CFG_IDX_W-1:0]  rd_index;
  logic                  rd_known;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        limits[i] <= '0;
      end
    end else if (wr_en && (wr_index < CFG_IDX_W'(NUM_CLASSES))) begin
      limits[wr_index] <= wr_data;
    end
  end

  // Class codes start at one; "other" and unused codes are never tested
  always_comb begin
    rd_known = 1'b1;
    rd_index = REG_MAG;
    case (rd_class)
      CLS_MAG:  rd_index = REG_MAG;
      CLS_GRAD: rd_index = REG_GRAD;
      CLS_EEG:  rd_index = REG_EEG;
      CLS_EOG:  rd_index = REG_EOG;
      CLS_ECG:  rd_index = REG_ECG;
      default:  rd_known = 1'b0;
    endcase
    sel.tested = rd_known;
    sel.reject = limits[rd_index][CFG_DATA_W-1:LIMIT_W];
    sel.flat   = limits[rd_index][LIMIT_W-1:0];
  end

endmodule

// File: rtl/epoch_peak_to_peak_rejector_core.sv
// Top level of the epoch peak-to-peak rejector.
//
//  channel   dir  payload                                          handshake
//  samples   in   sample_value, channel_class, channel_bad,         valid/ready
//                 last_of_channel, last_of_epoch
//  verdict   out  epoch_accepted, reject_reason, offending_channel, valid/ready
//                 offending_class
//  cfg       in   index (3 bits), data (64 bits)                    valid/ready
//
// One sample per cycle unless an epoch-end sample waits on a stalled verdict.
// Each sample sits in the input register, then min/max update, peak-to-peak subtract
// and limit compare write the state and, at epoch end, the verdict register.
// Synchronous reset clears limits and epoch state; cfg.ready is always high.
// A stalled verdict holds back only a following epoch-end sample.
module epoch_peak_to_peak_rejector_core import eppr_pkg::*; (
  input logic           clk,
  input logic           rst,
  eppr_sample_if.sink   samples,
  eppr_verdict_if.source verdict,
  eppr_cfg_if.sink      cfg
);

  // input register
  logic                       s_valid;
  logic signed [SAMPLE_W-1:0] s_sample;
  logic [CLASS_W-1:0]         s_class;
  logic                       s_bad;
  logic                       s_end_ch;
  logic                       s_end_ep;

  // epoch state
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic                       channel_start;
  logic [CH_IDX_W-1:0]        channel_index;
  logic                       rejected;
  logic [REASON_W-1:0]        held_reason;
  logic [OUT_CH_W-1:0]        held_channel;
  logic [CLASS_W-1:0]         held_class;

  // verdict register
  logic                o_valid;
  logic                o_accepted;
  logic [REASON_W-1:0] o_reason;
  logic [OUT_CH_W-1:0] o_channel;
  logic [CLASS_W-1:0]  o_class;

  logic                       advance;
  logic signed [SAMPLE_W-1:0] min_next;
  logic signed [SAMPLE_W-1:0] max_next;
  logic [SAMPLE_W:0]          diff;
  logic [LIMIT_W-1:0]         pp;
  limit_sel_t                 sel;
  logic                       tested;
  logic [REASON_W-1:0]        why;
  logic                       fail_now;
  logic [CH_IDX_W-1:0]        index_next;

  eppr_limit_regs u_limits (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .rd_class (s_class),
    .sel      (sel)
  );

  assign cfg.ready = 1'b1;

  // Only an epoch-end sample needs room in the verdict register
  assign advance       = s_valid && (!s_end_ep || !o_valid || verdict.ready);
  assign samples.ready = !s_valid || advance;

  always_comb begin
    if (channel_start) begin
      min_next = s_sample;
      max_next = s_sample;
    end else begin
      min_next = (s_sample < run_min) ? s_sample : run_min;
      max_next = (s_sample > run_max) ? s_sample : run_max;
    end
    diff = {max_next[SAMPLE_W-1], max_next} - {min_next[SAMPLE_W-1], min_next};
    pp   = diff[LIMIT_W-1:0];

    why = REASON_NONE;
    if ((sel.reject != '0) && (pp > sel.reject)) begin
      why = REASON_HIGH;
    end else if ((sel.flat != '0) && (pp < sel.flat)) begin
      why = REASON_FLAT;
    end
    tested   = (s_end_ch || s_end_ep) && !s_bad && sel.tested && !rejected;
    fail_now = tested && (why != REASON_NONE);

    if (channel_index == CH_IDX_W'(MAX_CHANNELS - 1)) begin
      index_next = '0;
    end else begin
      index_next = channel_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (samples.ready) begin
      s_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      s_sample <= samples.sample_value;
      s_class  <= samples.channel_class;
      s_bad    <= samples.channel_bad;
      s_end_ch <= samples.last_of_channel;
      s_end_ep <= samples.last_of_epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      run_min <= min_next;
      run_max <= max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_start <= 1'b1;
      channel_index <= '0;
      rejected      <= 1'b0;
      held_reason   <= REASON_NONE;
      held_channel  <= '0;
      held_class    <= '0;
    end else if (advance) begin
      if (s_end_ep) begin
        channel_start <= 1'b1;
        channel_index <= '0;
        rejected      <= 1'b0;
        held_reason   <= REASON_NONE;
        held_channel  <= '0;
        held_class    <= '0;
      end else if (s_end_ch) begin
        channel_start <= 1'b1;
        channel_index <= index_next;
        if (fail_now) begin
          rejected     <= 1'b1;
          held_reason  <= why;
          held_channel <= OUT_CH_W'(channel_index);
          held_class   <= s_class;
        end
      end else begin
        channel_start <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance && s_end_ep) begin
      o_valid <= 1'b1;
    end else if (verdict.ready) begin
      o_valid <= 1'b0;
    end
  end

  // The epoch's last channel may itself be the first failure
  always_ff @(posedge clk) begin
    if (advance && s_end_ep) begin
      if (rejected) begin
        o_accepted <= 1'b0;
        o_reason   <= held_reason;
        o_channel  <= held_channel;
        o_class    <= held_class;
      end else if (fail_now) begin
        o_accepted <= 1'b0;
        o_reason   <= why;
        o_channel  <= OUT_CH_W'(channel_index);
        o_class    <= s_class;
      end else begin
        o_accepted <= 1'b1;
        o_reason   <= REASON_NONE;
        o_channel  <= '0;
        o_class    <= '0;
      end
    end
  end

  assign verdict.valid             = o_valid;
  assign verdict.epoch_accepted    = o_accepted;
  assign verdict.reject_reason     = o_reason;
  assign verdict.offending_channel = o_channel;
  assign verdict.offending_class   = o_class;

endmodule

// File: rtl/eppr_port_checker.sv
// Port-level checks for the rejector core, bound to the top level.
`include "assert_macros.svh"

module eppr_port_checker import eppr_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_accepted,
  input logic [REASON_W-1:0] out_reason,
  input logic [OUT_CH_W-1:0] out_channel,
  input logic [CLASS_W-1:0]  out_class
);

  `ASSERT_ALWAYS(a_no_verdict_after_reset, rst |=> !out_valid, "verdict valid after reset")

  `ASSERT_RUN(a_verdict_held, out_valid && !out_ready |=> out_valid && $stable(out_accepted) && $stable(out_reason) && $stable(out_channel) && $stable(out_class), "stalled verdict changed")

  `ASSERT_RUN(a_accept_clean, out_valid && out_accepted |-> out_reason == REASON_NONE && out_channel == '0 && out_class == '0, "accepted epoch carries failure data")

  `ASSERT_RUN(a_reject_coded, out_valid && !out_accepted |-> (out_reason == REASON_HIGH || out_reason == REASON_FLAT) && out_class >= CLS_MAG && out_class <= CLS_ECG, "rejected epoch without reason or class")

endmodule

bind epoch_peak_to_peak_rejector_core eppr_port_checker u_port_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (verdict.valid),
  .out_ready    (verdict.ready),
  .out_accepted (verdict.epoch_accepted),
  .out_reason   (verdict.reject_reason),
  .out_channel  (verdict.offending_channel),
  .out_class    (verdict.offending_class)
);

// File: tb/sv/epoch_peak_to_peak_rejector_core_tb.sv
// Self-checking testbench for the epoch peak-to-peak rejector core.
`timescale 1ns / 100ps

module epoch_peak_to_peak_rejector_core_tb;
  import eppr_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int SETTLE      = 4;   // margin after the last verdict is checked
  localparam int WRAP_CHANS  = 520;
  localparam int WRAP_HIT    = 515;

  localparam logic [CLASS_W-1:0]   CLS_UNUSED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [CLASS_W-1:0]         cls;
    logic                       bad;
    logic                       end_ch;
    logic                       end_ep;
  } sample_t;

  typedef struct packed {
    logic                accepted;
    logic [REASON_W-1:0] reason;
    logic [OUT_CH_W-1:0] channel;
    logic [CLASS_W-1:0]  cls;
  } verdict_t;

  typedef enum bit [1:0] {ROW_CFG, ROW_SAMPLE, ROW_TYPED} row_kind_t;

  // cfg rows: sel is the register index, word the data; sample rows: word holds the sample
  typedef struct {
    row_kind_t             kind;
    logic [CFG_DATA_W-1:0] word;
    logic [CLASS_W-1:0]    sel;
    logic                  bad;
    logic                  end_ch;
    logic                  end_ep;
    verdict_t              want;
  } row_t;

  localparam verdict_t NO_VERDICT = '0;
  localparam verdict_t V_ACCEPT   = '{1'b1, REASON_NONE, '0, CLS_OTHER};

  logic clk = 1'b0;
  logic rst;

  eppr_sample_if  samples ();
  eppr_verdict_if verdict ();
  eppr_cfg_if     cfg ();

  epoch_peak_to_peak_rejector_core dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .verdict (verdict),
    .cfg     (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [CFG_DATA_W-1:0]      limit_regs [NUM_CLASSES] = '{default: '0};
  logic signed [SAMPLE_W-1:0] run_lo, run_hi;
  bit                         ch_fresh = 1'b1;
  int                         ch_count = 0;
  bit                         failed   = 1'b0;
  reason_t                    held_why = REASON_NONE;
  logic [OUT_CH_W-1:0]        held_ch  = '0;
  logic [CLASS_W-1:0]         held_cls = '0;

  verdict_t verdicts_due [$];
  row_t     directed [$];
  int       mismatches = 0;
  int       sent       = 0;
  bit       no_idle    = 1'b0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Advances min/max and the epoch verdict; returns 1 with the verdict on an epoch end
  function automatic bit track_sample(input sample_t s, output verdict_t v);
    logic [CFG_DATA_W-1:0] lim;
    logic [LIMIT_W-1:0]    pp;
    reason_t               why;
    v = NO_VERDICT;
    if (ch_fresh) begin
      run_lo   = s.value;
      run_hi   = s.value;
      ch_fresh = 1'b0;
    end else begin
      if ($signed(s.value) < run_lo) run_lo = s.value;
      if ($signed(s.value) > run_hi) run_hi = s.value;
    end
    if (s.end_ch || s.end_ep) begin
      if (!s.bad && s.cls >= CLS_MAG && s.cls <= CLS_ECG && !failed) begin
        // true span fits in 32 bits, so the wrapped difference is exact
        pp  = LIMIT_W'(run_hi - run_lo);
        lim = limit_regs[s.cls - 1];
        why = REASON_NONE;
        if (lim[CFG_DATA_W-1:LIMIT_W] != 0 && pp > lim[CFG_DATA_W-1:LIMIT_W])
          why = REASON_HIGH;
        else if (lim[LIMIT_W-1:0] != 0 && pp < lim[LIMIT_W-1:0])
          why = REASON_FLAT;
        if (why != REASON_NONE) begin
          failed   = 1'b1;
          held_why = why;
          held_ch  = OUT_CH_W'(ch_count);
          held_cls = s.cls;
        end
      end
      ch_count = (ch_count + 1 >= MAX_CHANNELS) ? 0 : ch_count + 1;
      ch_fresh = 1'b1;
    end
    if (!s.end_ep) return 1'b0;
    v = failed ? '{1'b0, held_why, held_ch, held_cls} : V_ACCEPT;
    ch_fresh = 1'b1;
    ch_count = 0;
    failed   = 1'b0;
    held_why = REASON_NONE;
    held_ch  = '0;
    held_cls = '0;
    return 1'b1;
  endfunction

  function automatic logic [CLASS_W-1:0] pick_class();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return CLS_OTHER;
    if (r == 1) return CLASS_W'($urandom_range(CLS_ECG + 1, CLS_UNUSED));
    return CLASS_W'($urandom_range(CLS_MAG, CLS_ECG));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limits(input int phase);
    logic [LIMIT_W-1:0] rej, flat;
    int r;
    r = $urandom_range(0, 9);
    if (phase == 0 || r == 0) return '0;
    if (phase == 1 || r == 1) return '1;
    if (r == 2) return {$urandom(), $urandom()};
    rej  = ($urandom_range(0, 3) == 0) ? '0 : LIMIT_W'($urandom_range(1, 3000));
    flat = ($urandom_range(0, 3) == 0) ? '0 : LIMIT_W'($urandom_range(1, 400));
    return {rej, flat};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Holds valid high across back-to-back transactions; the caller drops it
  task automatic send_sample(input sample_t s, input int gap, input bit typed,
                             input verdict_t want);
    verdict_t v;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid           <= 1'b1;
    samples.sample_value    <= s.value;
    samples.channel_class   <= s.cls;
    samples.channel_bad     <= s.bad;
    samples.last_of_channel <= s.end_ch;
    samples.last_of_epoch   <= s.end_ep;
    do @(posedge clk); while (!samples.ready);
    if (track_sample(s, v)) verdicts_due = {verdicts_due, typed ? want : v};
    sent++;
  endtask

  task automatic write_limits(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    if (idx <= REG_ECG) limit_regs[idx] = data;
  endtask

  task automatic quiesce();
    samples.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_epoch(input int n_ch);
    sample_t            s;
    logic [CLASS_W-1:0] cls;
    logic               bad;
    logic [SAMPLE_W-1:0] base;
    int                 len, spread;
    bit                 wide;
    for (int ch = 0; ch < n_ch; ch++) begin
      cls    = pick_class();
      bad    = ($urandom_range(0, 7) == 0);
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
      wide   = ($urandom_range(0, 9) == 0);
      base   = $urandom();
      spread = $urandom_range(0, 2500);
      for (int k = 0; k < len; k++) begin
        s.value  = wide ? $urandom() : base + $urandom_range(0, spread);
        s.cls    = cls;
        s.bad    = bad;
        s.end_ch = (k == len - 1);
        s.end_ep = (k == len - 1) && (ch == n_ch - 1);
        if (k != len - 1 && $urandom_range(0, 15) == 0) begin
          // only the flags on the closing sample count
          s.cls = pick_class();
          s.bad = 1'($urandom_range(0, 1));
        end
        if (k != len - 1 && $urandom_range(0, 39) == 0) s.end_ch = 1'b1;
        if (s.end_ep && $urandom_range(0, 3) == 0) s.end_ch = 1'b0;
        send_sample(s, idle_len(), 1'b0, NO_VERDICT);
      end
    end
  endtask

  // Runs the channel index past its wrap; one magnetometer channel fails late
  task automatic run_wrap_epoch();
    sample_t s;
    for (int ch = 0; ch < WRAP_CHANS; ch++) begin
      s.value  = $urandom();
      s.bad    = (ch != WRAP_HIT) && $urandom_range(0, 1);
      s.cls    = (ch == WRAP_HIT) ? CLS_MAG : (s.bad ? pick_class() : CLS_OTHER);
      s.end_ch = 1'b1;
      s.end_ep = (ch == WRAP_CHANS - 1);
      send_sample(s, idle_len(), 1'b0, NO_VERDICT);
    end
  endtask

  always @(posedge clk) begin : verdict_check
    verdict_t got, want;
    if (!rst && verdict.valid && verdict.ready) begin
      got = {verdict.epoch_accepted, verdict.reject_reason, verdict.offending_channel,
             verdict.offending_class};
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected verdict, accepted", got.accepted, 0);
      end else begin
        want = verdicts_due.pop_front();
        if (got.accepted != want.accepted)
          report_mismatch("epoch_accepted", got.accepted, want.accepted);
        if (got.reason != want.reason)
          report_mismatch("reject_reason", got.reason, want.reason);
        if (got.channel != want.channel)
          report_mismatch("offending_channel", got.channel, want.channel);
        if (got.cls != want.cls)
          report_mismatch("offending_class", got.cls, want.cls);
      end
    end
  end

  initial begin : verdict_backpressure
    int hold;
    forever begin
      verdict.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      hold = idle_len();
      if (hold > 0) begin
        verdict.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    sample_t s;
    rst                     <= 1'b1;
    samples.valid           <= 1'b0;
    samples.sample_value    <= '0;
    samples.channel_class   <= '0;
    samples.channel_bad     <= 1'b0;
    samples.last_of_channel <= 1'b0;
    samples.last_of_epoch   <= 1'b0;
    cfg.valid               <= 1'b0;
    cfg.index               <= '0;
    cfg.data                <= '0;

    directed = '{
      // limits all disabled after reset: full-scale swing passes
      '{ROW_SAMPLE, 64'h8000_0000, CLS_MAG, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_TYPED,  64'h7FFF_FFFF, CLS_MAG, 1'b0, 1'b1, 1'b1, V_ACCEPT},
      '{ROW_CFG, {32'd100, 32'd10}, REG_MAG, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_CFG, '1,                REG_GRAD, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_CFG, {32'd0, 32'd5},    REG_EEG, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_CFG, {32'd50, 32'd0},   REG_EOG, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_CFG, {32'd1, 32'd1},    REG_ECG, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      // classes in range pass, skipped and bad channels, flat limit at full scale
      '{ROW_SAMPLE, 64'd0,  CLS_MAG,   1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd50, CLS_MAG,   1'b0, 1'b1, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd5,  CLS_OTHER, 1'b0, 1'b1, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd0,  CLS_EEG,   1'b1, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd0,  CLS_EEG,   1'b1, 1'b1, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd7,  CLS_ECG,   1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd8,  CLS_ECG,   1'b0, 1'b1, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'h8000_0000, CLS_GRAD, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_TYPED,  64'h7FFF_FFFF, CLS_GRAD, 1'b0, 1'b1, 1'b1, V_ACCEPT},
      // flat first, later high failure ignored, epoch mark closes the channel
      '{ROW_SAMPLE, 64'd0,   CLS_MAG, 1'b0, 1'b1, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd0,   CLS_EOG, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd200, CLS_EOG, 1'b0, 1'b1, 1'b0, NO_VERDICT},
      '{ROW_TYPED,  64'd3,   CLS_EEG, 1'b0, 1'b0, 1'b1, '{1'b0, REASON_FLAT, '0, CLS_MAG}},
      // unused class skipped but counted, then a high failure on channel one
      '{ROW_SAMPLE, 64'd0,  CLS_UNUSED, 1'b0, 1'b1, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd0,  CLS_EOG,    1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, -51,    CLS_EOG,    1'b0, 1'b1, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd0,  CLS_OTHER,  1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_TYPED,  64'd0,  CLS_ECG,    1'b0, 1'b1, 1'b1,
        '{1'b0, REASON_HIGH, 9'd1, CLS_EOG}},
      // class and bad flag taken from the closing sample
      '{ROW_SAMPLE, 64'd0, CLS_MAG, 1'b1, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_TYPED,  64'd5, CLS_ECG, 1'b0, 1'b1, 1'b1, '{1'b0, REASON_HIGH, '0, CLS_ECG}},
      // write to an unmapped index leaves the limits alone
      '{ROW_CFG, '1, REG_SPARE, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd100, CLS_MAG, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, 64'd0,   CLS_MAG, 1'b0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_SAMPLE, -1,      CLS_MAG, 1'b0, 1'b1, 1'b1, NO_VERDICT}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (i == 0 || directed[i-1].kind != ROW_CFG) quiesce();
        write_limits(directed[i].sel, directed[i].word);
        if (i + 1 == directed.size() || directed[i+1].kind != ROW_CFG) cfg.valid <= 1'b0;
      end else begin
        s = '{directed[i].word[SAMPLE_W-1:0], directed[i].sel, directed[i].bad,
              directed[i].end_ch, directed[i].end_ep};
        send_sample(s, idle_len(), directed[i].kind == ROW_TYPED, directed[i].want);
      end
    end

    for (int phase = 0; sent < ITEM_TARGET; phase++) begin
      quiesce();
      no_idle = (phase % 4 == 3);
      for (int r = 0; r < NUM_CLASSES; r++)
        write_limits(CFG_IDX_W'(r), pick_limits(phase));
      if ($urandom_range(0, 2) == 0)
        write_limits(CFG_IDX_W'($urandom_range(NUM_CLASSES, REG_SPARE)), {$urandom(), $urandom()});
      if (phase == 2) write_limits(REG_MAG, {32'd0, 32'd1});
      cfg.valid <= 1'b0;
      if (phase == 2) begin
        run_wrap_epoch();
      end else begin
        repeat ($urandom_range(2, 6)) run_epoch($urandom_range(1, 10));
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("epoch_peak_to_peak_rejector_core_tb: PASS");
    end else begin
      $display("epoch_peak_to_peak_rejector_core_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("epoch_peak_to_peak_rejector_core_tb: FAIL");
    $finish;
  end

endmodule
